// ----- rtl/gfht_pkg.sv -----
// gfht_pkg: types, state codes, register indexes and reset values
// shared by the gnss fusion health tracker rtl; no dependencies
`default_nettype none

package gfht_pkg;

   localparam int TIME_BITS = 48;

   localparam int TIME_IN_W = 48;
   localparam int KIND_W    = 3;
   localparam int MODE_W    = 3;
   localparam int STATE_W   = 3;
   localparam int TMO_W     = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   localparam logic [KIND_W-1:0] FIX_KIND_3D     = 3'd3;
   localparam logic [MODE_W-1:0] FUSION_MODE_RUN = 3'd1;

   localparam logic [TMO_W-1:0] DEGRADE_TIMEOUT_RST = 32'd5000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEGRADE_TIMEOUT    = 2'd0,
      CSR_MIN_FIX_KIND       = 2'd1,
      CSR_FUSION_ACTIVE_CODE = 2'd2
   } csr_index_type;

   typedef enum logic [STATE_W-1:0] {
      ST_UNKNOWN     = 3'd0,
      ST_UNCAL       = 3'd1,
      ST_CALIBRATING = 3'd2,
      ST_FUSION      = 3'd3,
      ST_DEGRADED    = 3'd4,
      ST_LOST        = 3'd5
   } state_type;

   typedef struct packed {
      logic [TMO_W-1:0]  degrade_timeout;
      logic [KIND_W-1:0] min_fix_kind;
      logic [MODE_W-1:0] fusion_active_code;
   } cfg_type;

   typedef struct packed {
      logic [TIME_IN_W-1:0] time_ms;
      logic                 nav_present;
      logic [KIND_W-1:0]    gnss_fix_kind;
      logic                 fix_ok_flag;
      logic                 status_present;
      logic [MODE_W-1:0]    sensor_fusion_mode;
   } item_type;

   typedef struct packed {
      logic [STATE_W-1:0] prior_state;
      logic [STATE_W-1:0] state_after;
      logic               changed;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/gfht_if.sv -----
// gfht_req_if / gfht_rsp_if: valid-ready channels of the tracker
// depends on gfht_pkg for field widths
`default_nettype none

interface gfht_req_if;
   logic                           valid;
   logic                           ready;
   logic [gfht_pkg::TIME_IN_W-1:0] time_ms;
   logic                           nav_present;
   logic [gfht_pkg::KIND_W-1:0]    gnss_fix_kind;
   logic                           fix_ok_flag;
   logic                           status_present;
   logic [gfht_pkg::MODE_W-1:0]    sensor_fusion_mode;

   modport source (
      output valid, time_ms, nav_present, gnss_fix_kind, fix_ok_flag,
             status_present, sensor_fusion_mode,
      input  ready
   );
   modport sink (
      input  valid, time_ms, nav_present, gnss_fix_kind, fix_ok_flag,
             status_present, sensor_fusion_mode,
      output ready
   );
endinterface

interface gfht_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [gfht_pkg::STATE_W-1:0] prior_state;
   logic [gfht_pkg::STATE_W-1:0] state_after;
   logic                         changed;

   modport source (
      output valid, prior_state, state_after, changed,
      input  ready
   );
   modport sink (
      input  valid, prior_state, state_after, changed,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/gfht_csr.sv -----
// gfht_csr: configuration registers written through the csr port
// depends on gfht_pkg
`default_nettype none

module gfht_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [gfht_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [gfht_pkg::CSR_DAT_W-1:0] csr_wdata,
   output gfht_pkg::cfg_type                   cfg
);

   gfht_pkg::cfg_type cfg_ff;
   gfht_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (gfht_pkg::csr_index_type'(csr_index))
            gfht_pkg::CSR_DEGRADE_TIMEOUT: begin
               cfg_in.degrade_timeout = csr_wdata[gfht_pkg::TMO_W-1:0];
            end
            gfht_pkg::CSR_MIN_FIX_KIND: begin
               cfg_in.min_fix_kind = csr_wdata[gfht_pkg::KIND_W-1:0];
            end
            gfht_pkg::CSR_FUSION_ACTIVE_CODE: begin
               cfg_in.fusion_active_code = csr_wdata[gfht_pkg::MODE_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.degrade_timeout    <= gfht_pkg::DEGRADE_TIMEOUT_RST;
         cfg_ff.min_fix_kind       <= gfht_pkg::FIX_KIND_3D;
         cfg_ff.fusion_active_code <= gfht_pkg::FUSION_MODE_RUN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- rtl/gfht_core.sv -----
// gfht_core: fix flag, health state and entry time, one step per transaction
// depends on gfht_pkg
`default_nettype none

module gfht_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire gfht_pkg::item_type           item,
   input  wire gfht_pkg::cfg_type            cfg,
   output gfht_pkg::result_type              result,
   output gfht_pkg::state_type               cur_state
);

   gfht_pkg::state_type                  state_ff;
   gfht_pkg::state_type                  state_in;
   logic                                 fix_ff;
   logic                                 fix_in;
   logic [gfht_pkg::TIME_BITS-1:0]       entered_ff;
   logic [gfht_pkg::TIME_BITS-1:0]       now;
   logic [gfht_pkg::TIME_BITS-1:0]       elapsed;
   logic                                 timed_out;
   logic                                 go;

   assign now       = gfht_pkg::TIME_BITS'(item.time_ms);
   assign elapsed   = now - entered_ff;
   assign timed_out = elapsed > gfht_pkg::TIME_BITS'(cfg.degrade_timeout);

   always_comb begin
      fix_in = fix_ff;
      if (item.nav_present) begin
         fix_in = (item.gnss_fix_kind >= cfg.min_fix_kind) && item.fix_ok_flag;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gfht_pkg::ST_UNKNOWN: begin
            if (item.nav_present) begin
               state_in = fix_in ? gfht_pkg::ST_CALIBRATING : gfht_pkg::ST_UNCAL;
            end
         end
         gfht_pkg::ST_UNCAL: begin
            if (item.nav_present && fix_in) begin
               state_in = gfht_pkg::ST_CALIBRATING;
            end
         end
         gfht_pkg::ST_CALIBRATING: begin
            if (item.status_present && fix_in &&
                item.sensor_fusion_mode == cfg.fusion_active_code) begin
               state_in = gfht_pkg::ST_FUSION;
            end
         end
         gfht_pkg::ST_FUSION: begin
            if (item.nav_present && !fix_in) begin
               state_in = gfht_pkg::ST_DEGRADED;
            end
         end
         gfht_pkg::ST_DEGRADED: begin
            if (item.nav_present && fix_in) begin
               state_in = gfht_pkg::ST_FUSION;
            end else if (timed_out) begin
               state_in = gfht_pkg::ST_LOST;
            end
         end
         gfht_pkg::ST_LOST: begin
            if (item.nav_present && fix_in) begin
               state_in = gfht_pkg::ST_CALIBRATING;
            end
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   // a transition is any step that leaves the current state
   assign go = (state_in != state_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= gfht_pkg::ST_UNKNOWN;
         fix_ff     <= 1'b0;
         entered_ff <= '0;
      end else if (advance) begin
         fix_ff <= fix_in;
         if (go) begin
            state_ff   <= state_in;
            entered_ff <= now;
         end
      end
   end

   assign result.prior_state = state_ff;
   assign result.state_after = state_in;
   assign result.changed     = go;
   assign cur_state          = state_ff;

endmodule

`default_nettype wire

// ----- rtl/gnss_fusion_health_tracker_unit.sv -----
// gnss_fusion_health_tracker_unit: top level of the fusion health tracker
// depends on gfht_pkg, gfht_req_if, gfht_rsp_if, gfht_csr and gfht_core
//
// usage
//   req_chan carries one transaction per message: a timestamp plus an
//   optional position report and an optional fusion status report.
//   rsp_chan returns exactly one transaction per request with the state
//   before and after the message and a changed flag, in request order.
//   csr_we/csr_index/csr_wdata write degrade_timeout (0), min_fix_kind (1)
//   and fusion_active_code (2); other indexes are ignored. write only while
//   no request is in flight.
// pipeline
//   a request is captured in the input register, evaluated by the state
//   step in gfht_core and lands in the result register, which drives the
//   response. one request per cycle is sustained while rsp_chan.ready
//   stays high.
// reset
//   synchronous, active high: pipeline empty, state unknown, fix flag
//   clear, entry time zero, registers at their defaults.
// stall
//   with rsp_chan.ready low the result register holds, the input register
//   fills behind it, and req_chan.ready drops once both are occupied.
`default_nettype none

module gnss_fusion_health_tracker_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   gfht_req_if.sink                            req_chan,
   gfht_rsp_if.source                          rsp_chan,
   input  wire logic                           csr_we,
   input  wire logic [gfht_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [gfht_pkg::CSR_DAT_W-1:0] csr_wdata
);

   gfht_pkg::cfg_type    cfg;
   gfht_pkg::item_type   req_item;
   gfht_pkg::item_type   s1_item_ff;
   gfht_pkg::result_type core_res;
   gfht_pkg::result_type s2_res_ff;
   gfht_pkg::state_type  core_state;
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic                 s2_valid_ff;
   logic                 s2_valid_in;
   logic                 s2_free;
   logic                 s2_load;
   logic                 s1_free;

   gfht_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign req_item.time_ms            = req_chan.time_ms;
   assign req_item.nav_present        = req_chan.nav_present;
   assign req_item.gnss_fix_kind      = req_chan.gnss_fix_kind;
   assign req_item.fix_ok_flag        = req_chan.fix_ok_flag;
   assign req_item.status_present     = req_chan.status_present;
   assign req_item.sensor_fusion_mode = req_chan.sensor_fusion_mode;

   // pipeline handshake
   assign s2_free     = !s2_valid_ff || rsp_chan.ready;
   assign s2_load     = s1_valid_ff && s2_free;
   assign s1_free     = !s1_valid_ff || s2_load;
   assign s1_valid_in = s1_free ? req_chan.valid : s1_valid_ff;
   assign s2_valid_in = s2_free ? s1_valid_ff : s2_valid_ff;

   assign req_chan.ready = s1_free;

   gfht_core u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (s2_load),
      .item      (s1_item_ff),
      .cfg       (cfg),
      .result    (core_res),
      .cur_state (core_state)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free && req_chan.valid) begin
         s1_item_ff <= req_item;
      end
      if (s2_load) begin
         s2_res_ff <= core_res;
      end
   end

   assign rsp_chan.valid       = s2_valid_ff;
   assign rsp_chan.prior_state = s2_res_ff.prior_state;
   assign rsp_chan.state_after = s2_res_ff.state_after;
   assign rsp_chan.changed     = s2_res_ff.changed;

   // state register follows the step that was handed to the result register
   a_state_follows: assert property (@(posedge clock) disable iff (reset)
      s2_load |=> core_state == $past(core_res.state_after))
      else $error("state register does not match the last evaluated step");

   // input side only stalls when both stages are occupied
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (s1_valid_ff && s2_valid_ff && !rsp_chan.ready))
      else $error("request stalled with a free pipeline stage");

   // changed flag agrees with the reported states
   a_changed: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.changed ==
                          (rsp_chan.prior_state != rsp_chan.state_after)))
      else $error("changed flag disagrees with state pair");

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
